// ===== hdl/swm_pkg.sv =====
// Shared types and constants for the sliding window maximum filter.
// No dependencies; used by swm_cell and sliding_window_maximum.
package swm_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned WSIZE_W  = 7;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [WSIZE_W-1:0]         wsize_t;

  localparam wsize_t WSIZE_RESET = wsize_t'(3);

  // Register index decoded from the word address bit.
  localparam logic REG_WINDOW_SIZE = 1'b0;

endpackage

// ===== hdl/sliding_window_maximum.sv =====
// Sliding window maximum filter: top level with APB register, fill tracking and output stage.
// Depends on swm_pkg and swm_cell.
//
// Takes one signed sample per cycle while not stalled and, once
// window_size samples of the current sequence have arrived, returns the
// maximum of the latest window_size samples for every further sample;
// earlier samples return nothing. A sample with sequence_start high opens a
// new sequence. The maximum comes from a row of MAX_WINDOW compare cells: on
// every accepted item cell k takes max(sample, cell k-1), so cell k holds the
// maximum of the last k+1 samples and the result is the new value of cell
// window_size-1. The result appears in the output register in the cycle
// after acceptance; input is stalled only while a result waits in that
// register and the output is stalled. window_size 0 acts as 1 and
// values above MAX_WINDOW act as MAX_WINDOW; change it only while idle.
module sliding_window_maximum #(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // sample channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [15:0]          sample_i,
  input  logic                        sequence_start_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [15:0]          window_max_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [swm_pkg::APB_AW-1:0]  paddr,
  input  logic [swm_pkg::APB_DW-1:0]  pwdata,
  output logic [swm_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned FILL_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CMP_W  = (FILL_W > swm_pkg::WSIZE_W) ? FILL_W : swm_pkg::WSIZE_W;
  localparam logic [CMP_W-1:0] MAXW_C = CMP_W'(MAX_WINDOW);

  // ---------------- configuration ----------------
  swm_pkg::wsize_t wsize_d, wsize_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite
                  && (paddr[swm_pkg::APB_AW-1] == swm_pkg::REG_WINDOW_SIZE);

  always_comb begin
    wsize_d = wsize_q;
    if (cfg_wr) begin
      wsize_d = pwdata[swm_pkg::WSIZE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[swm_pkg::APB_AW-1] == swm_pkg::REG_WINDOW_SIZE) begin
      prdata = {{(swm_pkg::APB_DW - swm_pkg::WSIZE_W){1'b0}}, wsize_q};
    end
  end

  // effective window, clamped to 1..MAX_WINDOW
  logic [CMP_W-1:0] wsize_ext, win_eff;
  logic [IDX_W-1:0] tap_idx;

  assign wsize_ext = CMP_W'(wsize_q);

  always_comb begin
    win_eff = wsize_ext;
    if (wsize_ext == '0) begin
      win_eff = CMP_W'(1);
    end else if (wsize_ext > MAXW_C) begin
      win_eff = MAXW_C;
    end
  end

  assign tap_idx = IDX_W'(win_eff - CMP_W'(1));

  // ---------------- handshake ----------------
  logic in_acc;
  logic out_valid_d, out_valid_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  // ---------------- fill count ----------------
  logic [FILL_W-1:0] fill_d, fill_q;

  always_comb begin
    fill_d = fill_q;
    if (in_acc) begin
      if (sequence_start_i) begin
        fill_d = FILL_W'(1);
      end else if (fill_q != FILL_W'(MAX_WINDOW)) begin
        fill_d = fill_q + FILL_W'(1);
      end
    end
  end

  logic produce;
  assign produce = in_acc && (CMP_W'(fill_d) >= win_eff);

  // ---------------- cell row ----------------
  swm_pkg::sample_t cell_max [MAX_WINDOW];

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    swm_pkg::sample_t prev_max;
    if (k == 0) begin : g_head
      assign prev_max = sample_i;
    end else begin : g_link
      assign prev_max = cell_max[k-1];
    end
    swm_cell u_cell (
      .clk_i      (clk_i),
      .shift_i    (in_acc),
      .sample_i   (sample_i),
      .prev_max_i (prev_max),
      .max_o      (cell_max[k])
    );
  end

  // new value of the tap cell, same comparison the cell performs
  swm_pkg::sample_t tap_prev, tap_new;

  always_comb begin
    tap_prev = sample_i;
    if (tap_idx != '0) begin
      tap_prev = cell_max[tap_idx - IDX_W'(1)];
    end
    tap_new = (tap_prev > sample_i) ? tap_prev : sample_i;
  end

  // ---------------- output register ----------------
  swm_pkg::sample_t out_d, out_q;

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (produce) begin
      out_valid_d = 1'b1;
      out_d       = tap_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsize_q     <= swm_pkg::WSIZE_RESET;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wsize_q     <= wsize_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign window_max_o = out_q;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("input stalled with empty output register");

  a_start_resets_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && sequence_start_i) |=> (fill_q == FILL_W'(1)))
    else $error("sequence start did not restart fill count");

  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_acc))
    else $error("result appeared without an accepted item");

  a_unit_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (win_eff == CMP_W'(1))) |=> (out_valid_q && (out_q == $past(sample_i))))
    else $error("window of one did not return the sample");
`endif

endmodule

// ===== hdl/swm_cell.sv =====
// One compare cell of the running-maximum chain.
// Depends on swm_pkg for the sample type.
module swm_cell (
  input  logic             clk_i,
  input  logic             shift_i,
  input  swm_pkg::sample_t sample_i,
  input  swm_pkg::sample_t prev_max_i,
  output swm_pkg::sample_t max_o
);

  swm_pkg::sample_t max_d, max_q;

  // Cell k ends up holding the max of sample ages 0..k.
  always_comb begin
    max_d = max_q;
    if (shift_i) begin
      max_d = (prev_max_i > sample_i) ? prev_max_i : sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    max_q <= max_d;
  end

  assign max_o = max_q;

endmodule
